@@ hdl/bmhq_pkg.sv @@
// Shared opcode, status and width definitions for the binary max-heap queue.
`timescale 1ns / 1ps

package bmhq_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned COUNT_OUT_W = 8;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [COUNT_OUT_W-1:0] t_count_out;
    typedef logic [1:0] t_status;
    typedef logic t_opcode;

    localparam t_opcode OP_PUSH = 1'b0;
    localparam t_opcode OP_POP  = 1'b1;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

endpackage

@@ hdl/binary_max_heap_queue_unit.sv @@
// Binary max-heap priority queue kept in one synchronous memory, with its sequencer.
`timescale 1ns / 1ps

// Channel | Direction | Handshake                   | Payload
// in      | input     | i_in_valid / o_in_ready     | i_opcode, i_value
// out     | output    | o_out_valid / i_out_ready   | o_popped_value, o_top_value,
//         |           |                             | o_entry_count, o_is_empty, o_status
//
// Words are taken one at a time, only while the sequencer is idle, even while a finished
// result waits in the output register. Push: per level climbed, S_UP_RD reads the parent and
// S_UP_CMP compares and writes; at the root S_UP_RD writes the value. Pop: S_POP_LD takes the
// last entry as root; per level descended, S_DN_RD reads the children and S_DN_CMP compares
// and writes. Rejected words and emptying pops go straight to S_FIN. Reset clears the state,
// count and output valid only. A result that cannot leave holds the sequencer until it can.
module binary_max_heap_queue_unit #(
    parameter int unsigned CAPACITY = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bmhq_pkg::t_opcode   i_opcode,
    input  bmhq_pkg::t_data     i_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bmhq_pkg::t_data     o_popped_value,
    output bmhq_pkg::t_data     o_top_value,
    output bmhq_pkg::t_count_out o_entry_count,
    output logic                o_is_empty,
    output bmhq_pkg::t_status   o_status
);
    import bmhq_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned EW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_RD  = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_POP_LD = 3'd3;
    localparam logic [2:0] S_DN_RD  = 3'd4;
    localparam logic [2:0] S_DN_CMP = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    // Heap storage and its registered read ports.
    t_data r_mem [CAPACITY];
    t_data r_rd_a;
    t_data r_rd_b;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_data         w_wdata;
    logic [AW-1:0] w_raddr_a;
    logic [AW-1:0] w_raddr_b;

    // Control state.
    logic [2:0]    r_state,     n_state;
    logic [CW-1:0] r_count,     n_count;
    logic          r_out_valid, n_out_valid;

    // Datapath registers.
    t_data         r_v,      n_v;
    logic [AW-1:0] r_pos,    n_pos;
    logic [AW-1:0] r_par,    n_par;
    logic [AW-1:0] r_left,   n_left;
    logic [AW-1:0] r_right,  n_right;
    logic          r_right_ok, n_right_ok;
    t_data         r_popped, n_popped;
    t_status       r_status, n_status;
    t_data         r_root;

    t_data         r_o_popped, n_o_popped;
    t_data         r_o_top,    n_o_top;
    t_count_out    r_o_count,  n_o_count;
    logic          r_o_empty,  n_o_empty;
    t_status       r_o_status, n_o_status;

    logic [CW:0]   w_left;
    logic [CW:0]   w_right;
    logic [EW-1:0] w_cnt_ext;
    logic          w_sel_right;
    t_data         w_best_val;
    logic [AW-1:0] w_best_addr;
    logic          w_accept;

    function automatic logic greater(input t_data a, input t_data b);
        greater = (a > b);
    endfunction

    assign w_accept  = i_in_valid && (r_state == S_IDLE);
    assign w_left    = ((CW + 1)'(r_pos) << 1) | (CW + 1)'(1);
    assign w_right   = w_left + (CW + 1)'(1);
    assign w_cnt_ext = EW'(r_count);

    assign w_sel_right = r_right_ok && greater(r_rd_b, r_rd_a);
    assign w_best_val  = w_sel_right ? r_rd_b : r_rd_a;
    assign w_best_addr = w_sel_right ? r_right : r_left;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_v         = r_v;
        n_pos       = r_pos;
        n_par       = r_par;
        n_left      = r_left;
        n_right     = r_right;
        n_right_ok  = r_right_ok;
        n_popped    = r_popped;
        n_status    = r_status;
        n_o_popped  = r_o_popped;
        n_o_top     = r_o_top;
        n_o_count   = r_o_count;
        n_o_empty   = r_o_empty;
        n_o_status  = r_o_status;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = r_v;
        w_raddr_a   = r_par;
        w_raddr_b   = r_right;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_popped = '0;
                    n_status = ST_OK;
                    if (i_opcode == OP_PUSH) begin
                        if (r_count == FULL_COUNT) begin
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            n_v     = i_value;
                            n_pos   = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            n_popped = r_root;
                            n_count  = r_count - CW'(1);
                            // Fetch the last live entry; it becomes the new root.
                            w_raddr_a = n_count[AW-1:0];
                            n_state   = (n_count == '0) ? S_FIN : S_POP_LD;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_par     = (r_pos - AW'(1)) >> 1;
                    w_raddr_a = n_par;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                w_we = 1'b1;
                if (greater(r_v, r_rd_a)) begin
                    // Move the parent down into the hole and climb.
                    w_wdata = r_rd_a;
                    n_pos   = r_par;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_POP_LD: begin
                n_v     = r_rd_a;
                n_pos   = '0;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (w_left >= {1'b0, r_count}) begin
                    w_we    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_left     = w_left[AW-1:0];
                    n_right    = w_right[AW-1:0];
                    n_right_ok = (w_right < {1'b0, r_count});
                    w_raddr_a  = n_left;
                    w_raddr_b  = n_right;
                    n_state    = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                w_we = 1'b1;
                if (greater(w_best_val, r_v)) begin
                    // Pull the larger child up into the hole and descend.
                    w_wdata = w_best_val;
                    n_pos   = w_best_addr;
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_o_popped  = r_popped;
                    n_o_top     = (r_count != '0) ? r_root : '0;
                    n_o_count   = w_cnt_ext[COUNT_OUT_W-1:0];
                    n_o_empty   = (r_count == '0);
                    n_o_status  = r_status;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_a <= r_mem[w_raddr_a];
        r_rd_b <= r_mem[w_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v        <= n_v;
        r_pos      <= n_pos;
        r_par      <= n_par;
        r_left     <= n_left;
        r_right    <= n_right;
        r_right_ok <= n_right_ok;
        r_popped   <= n_popped;
        r_status   <= n_status;
        r_o_popped <= n_o_popped;
        r_o_top    <= n_o_top;
        r_o_count  <= n_o_count;
        r_o_empty  <= n_o_empty;
        r_o_status <= n_o_status;
        // Shadow copy of the root so the top word needs no extra read.
        if (w_we && (w_waddr == '0)) begin
            r_root <= w_wdata;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_o_popped;
    assign o_top_value    = r_o_top;
    assign o_entry_count  = r_o_count;
    assign o_is_empty     = r_o_empty;
    assign o_status       = r_o_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("heap count exceeds capacity");

    a_empty_top_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> (o_top_value == '0))
        else $error("empty result carries a nonzero top value");

    a_empty_pop_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_opcode == OP_POP) && (r_count == '0))
        |=> ((r_count == '0) && (r_state == S_FIN) && (r_status == ST_EMPTY)))
        else $error("pop from empty heap not rejected");

    a_full_push_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_opcode == OP_PUSH) && (r_count == FULL_COUNT))
        |=> ((r_count == FULL_COUNT) && (r_state == S_FIN) && (r_status == ST_FULL)))
        else $error("push to full heap not rejected");
`endif

endmodule

@@ sim/tb_binary_max_heap_queue_unit.sv @@
// Self-checking testbench for the binary max-heap queue unit.
`timescale 1ns / 1ps

module tb_binary_max_heap_queue_unit;
    import bmhq_pkg::*;

    localparam int CAPACITY = 128;
    localparam int RANDOM_WORDS = 1000;
    localparam int STALL_LIMIT = 1500;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        t_opcode op;
        t_data   value;
    } t_heap_word;

    typedef struct {
        t_data      popped;
        t_data      top;
        t_count_out count;
        logic       empty;
        t_status    status;
    } t_heap_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_opcode    i_opcode = OP_PUSH;
    t_data      i_value = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_data      o_popped_value;
    t_data      o_top_value;
    t_count_out o_entry_count;
    logic       o_is_empty;
    t_status    o_status;

    t_heap_word   pending_words[$];
    t_heap_result expected_results[$];
    t_data        heap_model [CAPACITY];
    int           model_fill = 0;
    int           gen_fill = 0;
    int           words_total = 0;
    int           words_accepted = 0;
    int           results_seen = 0;
    int           error_count = 0;
    int           stall_cycles = 0;

    binary_max_heap_queue_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_opcode(i_opcode),
        .i_value(i_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_popped_value(o_popped_value),
        .o_top_value(o_top_value),
        .o_entry_count(o_entry_count),
        .o_is_empty(o_is_empty),
        .o_status(o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one word to the heap copy and returns the result it should produce.
    function automatic t_heap_result apply_heap_op(t_opcode op, t_data val);
        t_heap_result r;
        int pos;
        int parent;
        int left;
        int best;
        t_data tmp;
        r.popped = '0;
        r.status = ST_OK;
        if (op == OP_PUSH) begin
            if (model_fill >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                heap_model[model_fill] = val;
                pos = model_fill;
                model_fill++;
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (!(heap_model[pos] > heap_model[parent])) break;
                    tmp = heap_model[pos];
                    heap_model[pos] = heap_model[parent];
                    heap_model[parent] = tmp;
                    pos = parent;
                end
            end
        end else begin
            if (model_fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.popped = heap_model[0];
                model_fill--;
                heap_model[0] = heap_model[model_fill];
                pos = 0;
                // Only live entries take part; ties keep the left child.
                while (2 * pos + 1 < model_fill) begin
                    left = 2 * pos + 1;
                    best = left;
                    if (left + 1 < model_fill && heap_model[left + 1] > heap_model[left])
                        best = left + 1;
                    if (!(heap_model[best] > heap_model[pos])) break;
                    tmp = heap_model[pos];
                    heap_model[pos] = heap_model[best];
                    heap_model[best] = tmp;
                    pos = best;
                end
            end
        end
        r.top = (model_fill > 0) ? heap_model[0] : '0;
        r.count = t_count_out'(model_fill);
        r.empty = (model_fill == 0);
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on result %0d: %s got %0d, want %0d", results_seen, field, got, want);
        error_count++;
    endtask

    // Queues a word and tracks how full the heap will be once it is applied.
    task automatic add_word(t_opcode op, t_data val);
        t_heap_word w;
        w.op = op;
        w.value = val;
        pending_words.push_back(w);
        words_total++;
        if (op == OP_PUSH && gen_fill < CAPACITY) gen_fill++;
        if (op == OP_POP && gen_fill > 0) gen_fill--;
    endtask

    function automatic t_data pick_value();
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 60) return t_data'($urandom());
        if (mode < 85) return t_data'($urandom_range(0, 8)) - 4;
        case ($urandom_range(0, 3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            default: return -1;
        endcase
    endfunction

    function automatic int draw_gap(inout int calm_left);
        if ($urandom_range(0, 31) == 0) calm_left = $urandom_range(10, 40);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    // Sender: offers queued words, idling for random gaps between them.
    int send_wait = 0;
    int send_calm = 0;
    always @(posedge i_clk) begin
        t_heap_word w;
        logic fire;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fire = i_in_valid && o_in_ready;
            if (fire) begin
                expected_results.push_back(apply_heap_op(i_opcode, i_value));
                words_accepted++;
                send_wait = draw_gap(send_calm);
            end
            if (!i_in_valid || fire) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    w = pending_words.pop_front();
                    i_in_valid <= 1'b1;
                    i_opcode <= w.op;
                    i_value <= w.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result word and stalls at random, twice for a long stretch.
    int recv_wait = 0;
    int recv_calm = 0;
    always @(posedge i_clk) begin
        t_heap_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_popped_value !== want.popped)
                        report_mismatch("popped_value", o_popped_value, want.popped);
                    if (o_top_value !== want.top)
                        report_mismatch("top_value", o_top_value, want.top);
                    if (o_entry_count !== want.count)
                        report_mismatch("entry_count", o_entry_count, want.count);
                    if (o_is_empty !== want.empty)
                        report_mismatch("is_empty", o_is_empty, want.empty);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                end
                results_seen++;
                if (results_seen == 100 || results_seen == 700)
                    recv_wait = HOLD_OFF_CYCLES;
                else
                    recv_wait = draw_gap(recv_calm);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int random_count;
        int phase;
        int kind;
        int start;
        // Directed words: empty pop, extreme and equal keys, full drain, repeated maximum.
        add_word(OP_POP, t_data'($urandom()));
        add_word(OP_PUSH, 32'sh7FFF_FFFF);
        add_word(OP_PUSH, 32'sh8000_0000);
        add_word(OP_PUSH, '0);
        add_word(OP_PUSH, -1);
        add_word(OP_PUSH, 5);
        add_word(OP_PUSH, 5);
        add_word(OP_PUSH, 5);
        add_word(OP_PUSH, 32'sh8000_0000);
        repeat (9) add_word(OP_POP, t_data'($urandom()));
        add_word(OP_PUSH, 32'sh7FFF_FFFF);
        add_word(OP_PUSH, 32'sh7FFF_FFFF);
        add_word(OP_POP, '1);
        add_word(OP_POP, '0);
        add_word(OP_POP, '0);

        // Random phases: fill up past full, drain past empty, or mix evenly.
        random_count = 0;
        phase = 0;
        while (random_count < RANDOM_WORDS) begin
            kind = (phase < 2) ? phase : $urandom_range(0, 2);
            start = words_total;
            if (kind == 0) begin
                while (gen_fill < CAPACITY) begin
                    if ($urandom_range(0, 99) < 85) add_word(OP_PUSH, pick_value());
                    else add_word(OP_POP, t_data'($urandom()));
                end
                repeat ($urandom_range(2, 6)) add_word(OP_PUSH, pick_value());
            end else if (kind == 1) begin
                while (gen_fill > 0) begin
                    if ($urandom_range(0, 99) < 85) add_word(OP_POP, t_data'($urandom()));
                    else add_word(OP_PUSH, pick_value());
                end
                repeat ($urandom_range(2, 6)) add_word(OP_POP, t_data'($urandom()));
            end else begin
                repeat (60) begin
                    if ($urandom_range(0, 1) == 0) add_word(OP_PUSH, pick_value());
                    else add_word(OP_POP, t_data'($urandom()));
                end
            end
            random_count += words_total - start;
            phase++;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_accepted < words_total) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/bmhq_pkg.sv
hdl/binary_max_heap_queue_unit.sv
sim/tb_binary_max_heap_queue_unit.sv
